>>> hdl/tlpa_pkg.sv
// ----------------------------------------------------------------------------
// tlpa_pkg
// Shared sizes, payload types, state and command types for the timed lease
// pool allocator.
// ----------------------------------------------------------------------------
package tlpa_pkg;

  // Pool capacity and time width
  localparam int unsigned POOL_MAX  = 16;
  localparam int unsigned TIME_BITS = 32;

  // Fixed field widths of the channels and the register
  localparam int unsigned FIELD_TIME_BITS = 32;
  localparam int unsigned POOL_CFG_BITS   = 5;
  localparam int unsigned ACTIVE_BITS     = 5;
  localparam int unsigned SERVED_BITS     = 32;

  // Derived sizes
  localparam int unsigned SLOT_BITS = (POOL_MAX > 1) ? $clog2(POOL_MAX) : 1;
  localparam int unsigned CNT_BITS  = $clog2(POOL_MAX + 1);
  localparam int unsigned CAP_BITS  = (CNT_BITS > POOL_CFG_BITS) ? CNT_BITS : POOL_CFG_BITS;

  localparam logic [POOL_CFG_BITS-1:0] POOL_SIZE_RESET = POOL_CFG_BITS'(2);
  localparam logic [SERVED_BITS-1:0]   SERVED_SAT      = '1;

  typedef logic [TIME_BITS-1:0] time_t;

  // Input beat
  typedef struct packed {
    logic [FIELD_TIME_BITS-1:0] start_time;
    logic [FIELD_TIME_BITS-1:0] end_time;
  } tlpa_in_t;

  // Output beat
  typedef struct packed {
    logic                   granted;
    logic [ACTIVE_BITS-1:0] active_leases;
    logic [SERVED_BITS-1:0] served_total;
  } tlpa_out_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_ALLOC
  } tlpa_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic release_exp;  // drop expired leases, capture the request
    logic alloc;        // grant a slot if free, load the output register
  } tlpa_cmd_t;

  // Fit a field time into the internal time width
  function automatic time_t to_time(input logic [FIELD_TIME_BITS-1:0] value);
    logic [TIME_BITS+FIELD_TIME_BITS-1:0] wide;
    wide = {{TIME_BITS{1'b0}}, value};
    return wide[TIME_BITS-1:0];
  endfunction

endpackage

>>> hdl/tlpa_ctrl.sv
// ----------------------------------------------------------------------------
// tlpa_ctrl
// Sequencer: takes one request, runs the release step on the accept edge and
// the allocation step once the output register is free; owns the output valid.
// ----------------------------------------------------------------------------
module tlpa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tlpa_pkg::tlpa_cmd_t cmd_o
);

  tlpa_pkg::tlpa_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;

  // Output register can take a new beat
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state and commands
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    in_stall_o       = 1'b1;
    out_valid_d      = out_valid_q && out_stall_i;
    unique case (state_q)
      tlpa_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.release_exp = 1'b1;
          state_d           = tlpa_pkg::ST_ALLOC;
        end
      end
      tlpa_pkg::ST_ALLOC: begin
        if (out_free) begin
          cmd_o.alloc = 1'b1;
          out_valid_d = 1'b1;
          state_d     = tlpa_pkg::ST_IDLE;
        end
      end
      default: state_d = tlpa_pkg::ST_IDLE;
    endcase
  end

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tlpa_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/tlpa_dp.sv
// ----------------------------------------------------------------------------
// tlpa_dp
// Datapath: lease slots with end times, pool size register, served counter
// and the output beat register.
// ----------------------------------------------------------------------------
module tlpa_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [tlpa_pkg::POOL_CFG_BITS-1:0]     cfg_data_i,
  input  tlpa_pkg::tlpa_in_t                     in_data_i,
  input  tlpa_pkg::tlpa_cmd_t                    cmd_i,
  output tlpa_pkg::tlpa_out_t                    out_data_o
);

  localparam int unsigned PM = tlpa_pkg::POOL_MAX;

  logic                 [PM-1:0] valid_q, valid_d;
  tlpa_pkg::time_t               lease_end_q [PM];
  tlpa_pkg::time_t               req_end_q;
  tlpa_pkg::time_t               req_start;
  logic [tlpa_pkg::POOL_CFG_BITS-1:0] pool_size_q;
  logic [tlpa_pkg::SERVED_BITS-1:0]   served_q, served_d;
  tlpa_pkg::tlpa_out_t                out_q;

  logic [tlpa_pkg::CNT_BITS-1:0]  active;
  logic [tlpa_pkg::CNT_BITS-1:0]  active_after;
  logic [tlpa_pkg::CAP_BITS-1:0]  cap;
  logic [tlpa_pkg::CAP_BITS-1:0]  pool_ext;
  logic [tlpa_pkg::SLOT_BITS-1:0] free_idx;
  logic                           free_found;
  logic                           grant;

  assign req_start = tlpa_pkg::to_time(in_data_i.start_time);

  // Count held leases after the release step
  always_comb begin
    active = '0;
    for (int i = 0; i < PM; i++) begin
      active = active + tlpa_pkg::CNT_BITS'(valid_q[i]);
    end
  end

  // Find the lowest free slot
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = PM - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx   = tlpa_pkg::SLOT_BITS'(i);
        free_found = 1'b1;
      end
    end
  end

  // Clamp pool size to the slot count
  assign pool_ext = tlpa_pkg::CAP_BITS'(pool_size_q);
  assign cap      = (pool_ext > tlpa_pkg::CAP_BITS'(PM)) ? tlpa_pkg::CAP_BITS'(PM) : pool_ext;
  assign grant    = cmd_i.alloc && free_found &&
                    (tlpa_pkg::CAP_BITS'(active) < cap);

  assign active_after = active + tlpa_pkg::CNT_BITS'(grant);
  assign served_d     = (grant && served_q != tlpa_pkg::SERVED_SAT) ?
                        served_q + tlpa_pkg::SERVED_BITS'(1) : served_q;

  // Next valid bits: drop expired leases on release, set the slot on grant
  always_comb begin
    valid_d = valid_q;
    if (cmd_i.release_exp) begin
      for (int i = 0; i < PM; i++) begin
        if (lease_end_q[i] <= req_start) begin
          valid_d[i] = 1'b0;
        end
      end
    end
    if (grant) begin
      valid_d[free_idx] = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      served_q    <= '0;
      pool_size_q <= tlpa_pkg::POOL_SIZE_RESET;
    end else begin
      valid_q  <= valid_d;
      served_q <= served_d;
      if (cfg_we_i) begin
        pool_size_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.release_exp) begin
      req_end_q <= tlpa_pkg::to_time(in_data_i.end_time);
    end
    if (grant) begin
      lease_end_q[free_idx] <= req_end_q;
    end
    if (cmd_i.alloc) begin
      out_q.granted       <= grant;
      out_q.active_leases <= tlpa_pkg::ACTIVE_BITS'(active_after);
      out_q.served_total  <= served_d;
    end
  end

  assign out_data_o = out_q;

endmodule

>>> hdl/timed_lease_pool_allocator.sv
// ----------------------------------------------------------------------------
// timed_lease_pool_allocator
// Hands out a pool of identical resources as timed leases.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_stall_o / in_data_i) carries a start and
//   an end time. On the accept edge every held lease ending at or before the
//   start is dropped; once the output register is free, the lowest free slot
//   is leased if fewer than pool_size are held, and the result beat is loaded.
//   Result channel (out_valid_o / out_stall_i / out_data_o) returns the grant
//   flag, the leases held afterward and the saturating served count.
//   Requests: a new request is accepted only after the allocate step of the
//   current one; the sequencer runs release, then allocate.
//   Stall: a waiting result sits in the output register while the next
//   request is accepted and released; allocation holds until that register
//   frees, and the request side stalls meanwhile.
//   Reset: all leases free, served count zero, pool_size 2. No clearing pass.
//   cfg_we_i writes pool_size; the user must do so only while the block is
//   idle, which the block does not enforce. Values above the slot count act
//   as the slot count.
module timed_lease_pool_allocator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tlpa_pkg::POOL_CFG_BITS-1:0] cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  tlpa_pkg::tlpa_in_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output tlpa_pkg::tlpa_out_t                out_data_o
);

  tlpa_pkg::tlpa_cmd_t cmd;

  // Sequencer
  tlpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Lease slots and counters
  tlpa_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .out_data_o (out_data_o)
  );

endmodule

>>> hdl/tlpa_checker.sv
// ----------------------------------------------------------------------------
// tlpa_checker
// Port-level checks for the timed lease pool allocator, bound to the top.
// ----------------------------------------------------------------------------
module tlpa_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input tlpa_pkg::tlpa_out_t                out_data_o
);

  // Hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // Stall requests while one is being allocated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted during allocation");

  // A granted lease is counted as held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.granted |-> out_data_o.active_leases != '0)
    else $error("grant reported with no active lease");

  // A grant implies a nonzero served count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.granted |-> out_data_o.served_total != '0)
    else $error("grant reported with zero served count");

endmodule

bind timed_lease_pool_allocator tlpa_checker u_tlpa_checker (.*);
